[src/blit_command_address_generator_macros.svh]
// ----------------------------------------------------------------------------
// blit command address generator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef BLIT_COMMAND_ADDRESS_GENERATOR_MACROS_SVH
`define BLIT_COMMAND_ADDRESS_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BCAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BCAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bcag_pkg.sv]
// ----------------------------------------------------------------------------
// bcag_pkg
// types, constants and helpers shared by the blit address generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcag_pkg;

  localparam int unsigned AddrW    = 26;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned BppW     = 3;
  localparam int unsigned PitchW   = 15;
  localparam int unsigned WbytesW  = 14;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CountW   = 5;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  localparam logic [CountW-1:0] MaxResults = 5'd29;
  localparam logic [CountW-1:0] LastPass   = MaxResults - 5'd1;

  localparam logic [SizeW-1:0] SizeMin = 13'd1;
  localparam logic [SizeW-1:0] SizeMax = 13'd4096;
  localparam logic [BppW-1:0]  BppMin  = 3'd1;
  localparam logic [BppW-1:0]  BppMax  = 3'd4;

  localparam logic [SizeW-1:0] SwReset  = 13'd1024;
  localparam logic [BppW-1:0]  BppReset = 3'd1;

  // request modes
  localparam logic [ModeW-1:0] ModeFill   = 2'd0;
  localparam logic [ModeW-1:0] ModeCopy   = 2'd1;
  localparam logic [ModeW-1:0] ModeExpand = 2'd2;
  localparam logic [ModeW-1:0] ModeNone   = 2'd3;

  // register indexes
  localparam logic [1:0] RegScreenWidth = 2'd0;
  localparam logic [1:0] RegBpp         = 2'd1;
  localparam logic [1:0] RegRtl         = 2'd2;
  localparam logic [1:0] RegBtt         = 2'd3;

  typedef struct packed {
    logic [SizeW-1:0] screen_width;
    logic [BppW-1:0]  bpp;
    logic             rtl;
    logic             btt;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic chunk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mode_ok;
    logic last;
  } status_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v < SizeMin) begin
      r = SizeMin;
    end else if (v > SizeMax) begin
      r = SizeMax;
    end
    return r;
  endfunction

  function automatic logic [BppW-1:0] clamp_bpp(input logic [BppW-1:0] v);
    logic [BppW-1:0] r;
    r = v;
    if (v < BppMin) begin
      r = BppMin;
    end else if (v > BppMax) begin
      r = BppMax;
    end
    return r;
  endfunction

endpackage

[src/bcag_regs.sv]
// ----------------------------------------------------------------------------
// bcag_regs
// apb configuration registers for the blit address generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcag_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcag_pkg::PaddrW-1:0] paddr,
  input  logic [bcag_pkg::PdataW-1:0] pwdata,
  output logic [bcag_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output bcag_pkg::cfg_t              cfg_o
);

  bcag_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        bcag_pkg::RegScreenWidth: cfg_d.screen_width = pwdata[bcag_pkg::SizeW-1:0];
        bcag_pkg::RegBpp:         cfg_d.bpp          = pwdata[bcag_pkg::BppW-1:0];
        bcag_pkg::RegRtl:         cfg_d.rtl          = pwdata[0];
        bcag_pkg::RegBtt:         cfg_d.btt          = pwdata[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width <= bcag_pkg::SwReset;
      cfg_q.bpp          <= bcag_pkg::BppReset;
      cfg_q.rtl          <= 1'b0;
      cfg_q.btt          <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      bcag_pkg::RegScreenWidth: prdata = 32'(cfg_q.screen_width);
      bcag_pkg::RegBpp:         prdata = 32'(cfg_q.bpp);
      bcag_pkg::RegRtl:         prdata = 32'(cfg_q.rtl);
      bcag_pkg::RegBtt:         prdata = 32'(cfg_q.btt);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/bcag_ctrl.sv]
// ----------------------------------------------------------------------------
// bcag_ctrl
// sequencer for the blit address generator: steps the datapath and owns
// the output word valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcag_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bcag_pkg::status_t status_i,
  output bcag_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StAdd   = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StChunk = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i && status_i.mode_ok) begin
          cmd_o.load = 1'b1;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StAdd;
      end
      StAdd: begin
        cmd_o.add = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = status_i.last ? StIdle : StChunk;
        end
      end
      StChunk: begin
        cmd_o.chunk = 1'b1;
        state_d     = StEmit;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/bcag_dp.sv]
// ----------------------------------------------------------------------------
// bcag_dp
// address datapath: operand setup, row multiply, column add, pass split
// and output word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcag_dp #(
  parameter int unsigned CHUNK_PIXELS = 144
) (
  input  logic                         clk_i,
  input  bcag_pkg::cmd_t               cmd_i,
  output bcag_pkg::status_t            status_o,
  input  bcag_pkg::cfg_t               cfg_i,
  input  logic [bcag_pkg::ModeW-1:0]   mode_i,
  input  logic [bcag_pkg::CoordW-1:0]  dst_x_i,
  input  logic [bcag_pkg::CoordW-1:0]  dst_y_i,
  input  logic [bcag_pkg::CoordW-1:0]  src_x_i,
  input  logic [bcag_pkg::CoordW-1:0]  src_y_i,
  input  logic [bcag_pkg::SizeW-1:0]   rect_width_i,
  input  logic [bcag_pkg::SizeW-1:0]   rect_height_i,
  output logic [bcag_pkg::AddrW-1:0]   src_addr_o,
  output logic [bcag_pkg::AddrW-1:0]   dst_addr_o,
  output logic [bcag_pkg::CoordW-1:0]  height_m1_o,
  output logic [bcag_pkg::WbytesW-1:0] width_bytes_m1_o,
  output logic [bcag_pkg::PitchW-1:0]  src_pitch_o,
  output logic                         bottom_to_top_o,
  output logic                         right_to_left_o,
  output logic                         last_o
);

  localparam int unsigned AW = bcag_pkg::AddrW;
  localparam int unsigned SW = bcag_pkg::SizeW;
  localparam int unsigned PW = bcag_pkg::PitchW;
  localparam int unsigned CW = bcag_pkg::CountW;
  localparam int unsigned MW = SW + PW;
  localparam logic [SW-1:0] ChunkPx = SW'(CHUNK_PIXELS);

  // request setup
  logic [SW-1:0]             sw_c, w_c, h_c, w_m1, h_m1_full;
  logic [bcag_pkg::BppW-1:0] bpp_c;
  logic                      is_fill, is_copy, is_expand, rtl_c, btt_c;
  logic [PW-1:0]             pitch_c, bpitch_c, spitch_c;
  logic [SW:0]               w_round;

  // working registers
  logic                      fill_q, expand_q, rtl_q, btt_q;
  logic [bcag_pkg::BppW-1:0] bpp_q;
  logic [PW-1:0]             pitch_q, spitch_q;
  logic [SW-1:0]             row_s_q, row_d_q, col_s_q, col_d_q;
  logic [bcag_pkg::CoordW-1:0] h_m1_q;
  logic [AW-1:0]             prod_s_q, prod_d_q, addr_s_q, addr_d_q;
  logic [PW-1:0]             cterm_s_q, cterm_d_q;
  logic [SW-1:0]             todo_q, ww_q;
  logic [PW-1:0]             wb_q;
  logic [CW-1:0]             k_q;

  logic [MW-1:0]             mul_s, mul_d;
  logic [PW-1:0]             off, scaled_s, scaled_d;
  logic [SW-1:0]             ww_n;
  logic [PW-1:0]             wb_n;
  logic                      last_c;

  assign sw_c      = bcag_pkg::clamp_size(cfg_i.screen_width);
  assign bpp_c     = bcag_pkg::clamp_bpp(cfg_i.bpp);
  assign w_c       = bcag_pkg::clamp_size(rect_width_i);
  assign h_c       = bcag_pkg::clamp_size(rect_height_i);
  assign w_m1      = w_c - SW'(1);
  assign h_m1_full = h_c - SW'(1);
  assign is_fill   = (mode_i == bcag_pkg::ModeFill);
  assign is_copy   = (mode_i == bcag_pkg::ModeCopy);
  assign is_expand = (mode_i == bcag_pkg::ModeExpand);
  assign rtl_c     = is_copy & cfg_i.rtl;
  assign btt_c     = is_copy & cfg_i.btt;
  assign pitch_c   = PW'(sw_c) * PW'(bpp_c);
  // bitmap pitch: width rounded up to 32 pixels, in bytes
  assign w_round   = (SW+1)'(w_c) + (SW+1)'(31);
  assign bpitch_c  = PW'({w_round[SW:5], 2'b00});
  assign spitch_c  = is_expand ? bpitch_c : pitch_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fill_q   <= is_fill;
      expand_q <= is_expand;
      rtl_q    <= rtl_c;
      btt_q    <= btt_c;
      bpp_q    <= bpp_c;
      pitch_q  <= pitch_c;
      spitch_q <= spitch_c;
      h_m1_q   <= h_m1_full[bcag_pkg::CoordW-1:0];
      row_s_q  <= SW'(src_y_i) + (btt_c ? h_m1_full : '0);
      row_d_q  <= SW'(dst_y_i) + (btt_c ? h_m1_full : '0);
      col_s_q  <= SW'(src_x_i) + (rtl_c ? w_m1 : '0);
      col_d_q  <= SW'(dst_x_i) + (rtl_c ? w_m1 : '0);
      todo_q   <= w_c;
      k_q      <= '0;
    end else if (cmd_i.emit && !last_c) begin
      todo_q   <= todo_q - ww_q;
      k_q      <= k_q + CW'(1);
    end
  end

  // row multiply and column terms
  assign mul_s    = MW'(row_s_q) * MW'(pitch_q);
  assign mul_d    = MW'(row_d_q) * MW'(pitch_q);
  assign off      = rtl_q ? (PW'(bpp_q) - PW'(1)) : '0;
  assign scaled_s = PW'(col_s_q) * PW'(bpp_q) + off;
  assign scaled_d = PW'(col_d_q) * PW'(bpp_q) + off;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_s_q  <= mul_s[AW-1:0];
      prod_d_q  <= mul_d[AW-1:0];
      cterm_s_q <= expand_q ? PW'(col_s_q) : scaled_s;
      cterm_d_q <= scaled_d;
    end
  end

  // pass split
  always_comb begin
    ww_n = todo_q;
    if (expand_q && (k_q != bcag_pkg::LastPass) && (todo_q > ChunkPx)) begin
      ww_n = ChunkPx;
    end
  end

  assign wb_n   = PW'(ww_n) * PW'(bpp_q);
  assign last_c = (todo_q == ww_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.add || cmd_i.chunk) begin
      ww_q <= ww_n;
      wb_q <= wb_n;
    end
    if (cmd_i.add) begin
      addr_s_q <= fill_q ? '0 : prod_s_q + AW'(cterm_s_q);
      addr_d_q <= prod_d_q + AW'(cterm_d_q);
    end else if (cmd_i.emit && !last_c) begin
      addr_s_q <= addr_s_q + AW'(ww_q);
      addr_d_q <= addr_d_q + AW'(wb_q);
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      src_addr_o       <= addr_s_q;
      dst_addr_o       <= addr_d_q;
      height_m1_o      <= h_m1_q;
      width_bytes_m1_o <= bcag_pkg::WbytesW'(wb_q - PW'(1));
      src_pitch_o      <= spitch_q;
      bottom_to_top_o  <= btt_q;
      right_to_left_o  <= rtl_q;
      last_o           <= last_c;
    end
  end

  assign status_o.mode_ok = (mode_i != bcag_pkg::ModeNone);
  assign status_o.last    = last_c;

endmodule

[src/blit_command_address_generator.sv]
// ----------------------------------------------------------------------------
// blit_command_address_generator
// turns fill, copy and colour-expand requests into blitter command words
//
//   channel   handshake                 contents
//   in        in_valid_i / in_ready_o   mode, dst/src corner, rect size
//   out       out_valid_o / out_ready_i addresses, sizes, pitch, dirs, last
//   cfg       apb psel/penable/pwrite   screen width, bpp, copy directions
//
// a request reaches its first word through accept, row multiply,
// column add, then the output register load
// each further colour-expand pass steps through an advance and a pass split
// a new request is taken once the last word sits in the output register
// output stalls hold the sequencer in place; no reset sweep is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blit_command_address_generator #(
  parameter int unsigned CHUNK_PIXELS = 144
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bcag_pkg::ModeW-1:0]   mode_i,
  input  logic [bcag_pkg::CoordW-1:0]  dst_x_i,
  input  logic [bcag_pkg::CoordW-1:0]  dst_y_i,
  input  logic [bcag_pkg::CoordW-1:0]  src_x_i,
  input  logic [bcag_pkg::CoordW-1:0]  src_y_i,
  input  logic [bcag_pkg::SizeW-1:0]   rect_width_i,
  input  logic [bcag_pkg::SizeW-1:0]   rect_height_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bcag_pkg::AddrW-1:0]   src_addr_o,
  output logic [bcag_pkg::AddrW-1:0]   dst_addr_o,
  output logic [bcag_pkg::CoordW-1:0]  height_m1_o,
  output logic [bcag_pkg::WbytesW-1:0] width_bytes_m1_o,
  output logic [bcag_pkg::PitchW-1:0]  src_pitch_o,
  output logic                         bottom_to_top_o,
  output logic                         right_to_left_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcag_pkg::PaddrW-1:0]  paddr,
  input  logic [bcag_pkg::PdataW-1:0]  pwdata,
  output logic [bcag_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);

  bcag_pkg::cfg_t    cfg;
  bcag_pkg::cmd_t    cmd;
  bcag_pkg::status_t status;

  bcag_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bcag_dp #(
    .CHUNK_PIXELS (CHUNK_PIXELS)
  ) u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg),
    .mode_i           (mode_i),
    .dst_x_i          (dst_x_i),
    .dst_y_i          (dst_y_i),
    .src_x_i          (src_x_i),
    .src_y_i          (src_y_i),
    .rect_width_i     (rect_width_i),
    .rect_height_i    (rect_height_i),
    .src_addr_o       (src_addr_o),
    .dst_addr_o       (dst_addr_o),
    .height_m1_o      (height_m1_o),
    .width_bytes_m1_o (width_bytes_m1_o),
    .src_pitch_o      (src_pitch_o),
    .bottom_to_top_o  (bottom_to_top_o),
    .right_to_left_o  (right_to_left_o),
    .last_o           (last_o)
  );

endmodule

[src/bcag_checker.sv]
// ----------------------------------------------------------------------------
// bcag_checker
// port-level checks for the blit address generator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "blit_command_address_generator_macros.svh"

module bcag_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [bcag_pkg::ModeW-1:0] mode_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [bcag_pkg::AddrW-1:0] src_addr_o,
  input logic                       last_o
);

  // a stalled word holds
  `BCAG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(src_addr_o), "output word changed while stalled")

  // a real request closes the input side
  `BCAG_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o && (mode_i != bcag_pkg::ModeNone), !in_ready_o, "input still open after a request")

  // an unused mode is dropped
  `BCAG_ASSERT_NEXT(a_drop_unused, in_valid_i && in_ready_o && (mode_i == bcag_pkg::ModeNone), in_ready_o && !out_valid_o || in_ready_o, "unused mode blocked the input")

  // no new request while passes remain
  `BCAG_ASSERT_NOW(a_no_accept_mid, out_valid_o && !last_o, !in_ready_o, "input open before the last word")

endmodule

bind blit_command_address_generator bcag_checker u_bcag_checker (.*);
